// ----- hdl/pcfe_pkg.sv -----
// shared types, constants and combinational helpers for the payload frame encoder
// no dependencies; imported by every module of the block
`default_nettype none

package pcfe_pkg;

	localparam int unsigned PAYLOAD_W   = 24;
	localparam int unsigned MSG_W       = 32;
	localparam int unsigned CODED_W     = 80;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned FRAME_BYTES = 12;
	localparam int unsigned IDX_W       = 4;
	localparam int unsigned CFG_IDX_W   = 2;

	localparam logic [IDX_W-1:0]  IDX_SYNC_FIRST  = 4'd0;
	localparam logic [IDX_W-1:0]  IDX_SYNC_SECOND = 4'd1;
	localparam logic [IDX_W-1:0]  IDX_LAST        = 4'(FRAME_BYTES - 1);

	localparam logic [31:0] CHECK_INIT  = 32'hffff_ffff;
	localparam logic [31:0] CHECK_POLY  = 32'h0000_00e0;
	localparam logic [8:0]  CONV_POLY_A = 9'h1af;
	localparam logic [8:0]  CONV_POLY_B = 9'h11d;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hf9;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'ha8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYNC_FIRST  = 2'd0,
		CFG_SYNC_SECOND = 2'd1
	} cfg_reg_t;

	// one byte through the reflected check register, eight shifts
	function automatic logic [31:0] check_byte_step(input logic [31:0] r_in,
			input logic [7:0] b);
		logic [31:0] r;
		logic        low;
		r = r_in ^ {24'h0, b};
		for (int s = 0; s < 8; s++) begin
			low = r[0];
			r   = r >> 1;
			if (low) begin
				r = r ^ CHECK_POLY;
			end
		end
		return r;
	endfunction

	// k=9 rate 1/2 code over 32 message bits plus eight zero tail bits
	// symbol 0 lands in the top two bits of the result
	function automatic logic [CODED_W-1:0] conv_encode(input logic [MSG_W-1:0] msg);
		logic [51:0]        ext;
		logic [8:0]         win;
		logic [CODED_W-1:0] c;
		ext = '0;
		c   = '0;
		for (int p = 0; p < 32; p++) begin
			ext[p + 12] = msg[31 - p];
		end
		for (int sym = 0; sym < 40; sym++) begin
			for (int j = 0; j < 9; j++) begin
				win[j] = ext[sym - j + 12];
			end
			c[79 - 2*sym]     = ^(win & CONV_POLY_A);
			c[79 - 2*sym - 1] = ^(win & CONV_POLY_B);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/pcfe_check_pipe.sv -----
// three-stage check byte pipeline, one payload byte per stage
// depends on pcfe_pkg
`default_nettype none

module pcfe_check_pipe import pcfe_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PAYLOAD_W-1:0] payload,
	output logic                      msg_valid,
	input  wire logic                 msg_ready,
	output logic [MSG_W-1:0]          msg
);

	logic                 v_s1, v_s2, v_s3;
	logic [PAYLOAD_W-1:0] pl_s1, pl_s2;
	logic [31:0]          crc_s1, crc_s2;
	logic [MSG_W-1:0]     msg_s3;
	logic                 ld1, ld2, ld3;
	logic [31:0]          crc_last;

	assign ld3 = !v_s3 || msg_ready;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign in_stall = !ld1;

	assign crc_last = check_byte_step(crc_s2, pl_s2[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			pl_s1  <= payload;
			crc_s1 <= check_byte_step(CHECK_INIT, payload[23:16]);
		end
		if (ld2 && v_s1) begin
			pl_s2  <= pl_s1;
			crc_s2 <= check_byte_step(crc_s1, pl_s1[15:8]);
		end
		if (ld3 && v_s2) begin
			msg_s3 <= {pl_s2, ~crc_last[7:0]};
		end
	end

	assign msg_valid = v_s3;
	assign msg       = msg_s3;

endmodule

`default_nettype wire

// ----- hdl/pcfe_conv_stage.sv -----
// convolutional encoder stage: 32 message bits to ten coded bytes
// depends on pcfe_pkg
`default_nettype none

module pcfe_conv_stage import pcfe_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             msg_valid,
	output logic                  msg_ready,
	input  wire logic [MSG_W-1:0] msg,
	output logic                  coded_valid,
	input  wire logic             coded_ready,
	output logic [CODED_W-1:0]    coded
);

	logic               v_s4;
	logic [CODED_W-1:0] coded_s4;
	logic               ld4;

	assign ld4       = !v_s4 || coded_ready;
	assign msg_ready = ld4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ld4) begin
			v_s4 <= msg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld4 && msg_valid) begin
			coded_s4 <= conv_encode(msg);
		end
	end

	assign coded_valid = v_s4;
	assign coded       = coded_s4;

endmodule

`default_nettype wire

// ----- hdl/pcfe_serializer.sv -----
// frame buffer and output register: two sync bytes then ten coded bytes
// depends on pcfe_pkg
`default_nettype none

module pcfe_serializer import pcfe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               coded_valid,
	output logic                    coded_ready,
	input  wire logic [CODED_W-1:0] coded,
	input  wire logic [BYTE_W-1:0]  sync_first,
	input  wire logic [BYTE_W-1:0]  sync_second,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [BYTE_W-1:0]       frame_byte,
	output logic                    last_byte
);

	logic               fvalid_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CODED_W-1:0] shift_q;
	logic               ovalid_q;
	logic [BYTE_W-1:0]  obyte_q;
	logic               olast_q;
	logic               out_take;
	logic               emit;
	logic               emit_last;
	logic [BYTE_W-1:0]  next_byte;

	assign out_take    = !ovalid_q || !out_stall;
	assign emit        = out_take && fvalid_q;
	assign emit_last   = idx_q == IDX_LAST;
	assign coded_ready = !fvalid_q || (emit && emit_last);

	always_comb begin
		unique case (idx_q)
			IDX_SYNC_FIRST:  next_byte = sync_first;
			IDX_SYNC_SECOND: next_byte = sync_second;
			default:         next_byte = shift_q[CODED_W-1 -: BYTE_W];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q <= 1'b0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (coded_ready) begin
				fvalid_q <= coded_valid;
				idx_q    <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_take) begin
				ovalid_q <= fvalid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (coded_ready && coded_valid) begin
			shift_q <= coded;
		end else if (emit && idx_q != IDX_SYNC_FIRST && idx_q != IDX_SYNC_SECOND) begin
			shift_q <= shift_q << BYTE_W;
		end
		if (emit) begin
			obyte_q <= next_byte;
			olast_q <= emit_last;
		end
	end

	assign out_valid  = ovalid_q;
	assign frame_byte = obyte_q;
	assign last_byte  = olast_q;

endmodule

`default_nettype wire

// ----- hdl/payload_crc8_conv_frame_encoder.sv -----
// top level of the payload frame encoder: config registers and stage wiring
// depends on pcfe_pkg, pcfe_check_pipe, pcfe_conv_stage, pcfe_serializer
//
// usage
//  - input channel: one 24-bit payload per beat on payload, in_valid / in_stall
//  - output channel: twelve beats per payload on frame_byte, out_valid / out_stall;
//    sync_byte_first, sync_byte_second, then ten coded bytes; last_byte marks the twelfth
//  - config channel: cfg_valid / cfg_ready, cfg_index 0 = first sync byte,
//    1 = second sync byte, other indexes ignored; cfg_ready is always high;
//    write only while no frame is in flight
//  - order: the first byte of a frame passes the three check byte stages, the
//    encoder stage, the frame buffer and the output register before it shows
//  - throughput: one output byte per cycle while out_stall is low and a frame
//    is buffered; the single output byte port of the serializer sets that rate
//  - the five stages hold up to five payloads, so beats are taken back to
//    back until the pipeline fills behind a busy serializer
//  - reset: pipeline empty, sync bytes return to 0xf9 and 0xa8
//  - a stalled receiver holds the output byte; stall ripples back stage by
//    stage and in_stall rises only once every stage is full
`default_nettype none

module payload_crc8_conv_frame_encoder import pcfe_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// payload beats
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PAYLOAD_W-1:0] payload,
	// frame byte beats
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [BYTE_W-1:0]         frame_byte,
	output logic                      last_byte,
	// register writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	logic [BYTE_W-1:0]  sync_first_q;
	logic [BYTE_W-1:0]  sync_second_q;
	logic               msg_valid, msg_ready;
	logic [MSG_W-1:0]   msg;
	logic               coded_valid, coded_ready;
	logic [CODED_W-1:0] coded;

	// register file never back-pressures
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stages 1..3: check byte over the three payload bytes
	pcfe_check_pipe u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.payload   (payload),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg)
	);

	// stage 4: convolutional code with tail
	pcfe_conv_stage u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_valid   (msg_valid),
		.msg_ready   (msg_ready),
		.msg         (msg),
		.coded_valid (coded_valid),
		.coded_ready (coded_ready),
		.coded       (coded)
	);

	// frame buffer and output register, one byte per beat
	pcfe_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.coded_valid (coded_valid),
		.coded_ready (coded_ready),
		.coded       (coded),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

endmodule

`default_nettype wire
